>>> rtl/rsi_pkg.sv
// Shared widths, types and codes of the ray-sphere intersection pipeline.
package rsi_pkg;

  localparam int unsigned COORD_W     = 32;
  localparam int unsigned RAD_W       = 31;
  localparam int unsigned Q_W         = 33;
  localparam int unsigned DD_W        = 64;
  localparam int unsigned DQ_W        = 65;
  localparam int unsigned QQ_W        = 66;
  localparam int unsigned RR_W        = 62;
  localparam int unsigned A_W         = 64;
  localparam int unsigned B_W         = 66;
  localparam int unsigned C_W         = 67;
  localparam int unsigned BMAG_W      = 65;
  localparam int unsigned CMAG_W      = 66;
  localparam int unsigned MUL_W       = 66;
  localparam int unsigned PROD_W      = 132;
  localparam int unsigned DISC_W      = 132;
  localparam int unsigned T_W         = 32;
  localparam int unsigned IN_TDATA_W  = 320;
  localparam int unsigned OUT_TDATA_W = 32;
  localparam int unsigned MUL_LAT     = 3;

  // how the numerator is formed from |B|<<F and the root
  typedef enum logic [1:0] {
    NSEL_SUB_CEIL,
    NSEL_ADD,
    NSEL_REV
  } nsel_e;

  typedef struct packed {
    logic a_nz;
    logic b_neg;
    logic b_zero;
    logic c_neg;
    logic c_zero;
  } sign_flags_t;

  typedef struct packed {
    logic [A_W-1:0]    a;
    logic [BMAG_W-1:0] bmag;
    sign_flags_t       flags;
  } mul_side_t;

  typedef struct packed {
    logic [A_W-1:0]    a;
    logic [BMAG_W-1:0] bmag;
    logic              hit;
    nsel_e             nsel;
  } root_side_t;

endpackage

>>> rtl/rsi_front.sv
// Front end: q = origin - center, coordinate products, and A, |B|, |C| with signs.
module rsi_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  logic [rsi_pkg::COORD_W-1:0]  origin_i [3],
  input  logic [rsi_pkg::COORD_W-1:0]  dir_i    [3],
  input  logic [rsi_pkg::COORD_W-1:0]  center_i [3],
  input  logic [rsi_pkg::RAD_W-1:0]    radius_i,
  output logic                         valid_o,
  output logic [rsi_pkg::A_W-1:0]      a_o,
  output logic [rsi_pkg::BMAG_W-1:0]   bmag_o,
  output logic [rsi_pkg::CMAG_W-1:0]   cmag_o,
  output rsi_pkg::sign_flags_t         flags_o
);

  logic [3:0] vld_q;

  logic signed [rsi_pkg::COORD_W-1:0] d_q  [3];
  logic signed [rsi_pkg::Q_W-1:0]     q_q  [3];
  logic        [rsi_pkg::RAD_W-1:0]   r_q;

  logic signed [rsi_pkg::DD_W-1:0]    dd_d [3], dd_q [3];
  logic signed [rsi_pkg::DQ_W-1:0]    dq_d [3], dq_q [3];
  logic signed [rsi_pkg::QQ_W-1:0]    qq_d [3], qq_q [3];
  logic        [rsi_pkg::RR_W-1:0]    rr_q;

  logic        [rsi_pkg::A_W-1:0]     a_d, a_q, a2_q;
  logic signed [rsi_pkg::B_W-1:0]     b_d, b_q;
  logic signed [rsi_pkg::C_W-1:0]     c_d, c_q;
  logic        [rsi_pkg::B_W-1:0]     babs;
  logic        [rsi_pkg::C_W-1:0]     cabs;
  logic        [rsi_pkg::BMAG_W-1:0]  bmag_q;
  logic        [rsi_pkg::CMAG_W-1:0]  cmag_q;
  rsi_pkg::sign_flags_t               flags_d, flags_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dd_d[i] = d_q[i] * d_q[i];
      dq_d[i] = d_q[i] * q_q[i];
      qq_d[i] = q_q[i] * q_q[i];
    end
    a_d = $unsigned(dd_q[0]) + $unsigned(dd_q[1]) + $unsigned(dd_q[2]);
    b_d = dq_q[0] + dq_q[1] + dq_q[2];
    c_d = qq_q[0] + qq_q[1] + qq_q[2] - $signed({1'b0, rr_q});
    babs = b_q[rsi_pkg::B_W-1] ? $unsigned(-b_q) : $unsigned(b_q);
    cabs = c_q[rsi_pkg::C_W-1] ? $unsigned(-c_q) : $unsigned(c_q);
    flags_d.a_nz   = (a_q != '0);
    flags_d.b_neg  = b_q[rsi_pkg::B_W-1];
    flags_d.b_zero = (b_q == '0);
    flags_d.c_neg  = c_q[rsi_pkg::C_W-1];
    flags_d.c_zero = (c_q == '0);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        d_q[i]  <= $signed(dir_i[i]);
        q_q[i]  <= $signed({origin_i[i][rsi_pkg::COORD_W-1], origin_i[i]}
                           - {center_i[i][rsi_pkg::COORD_W-1], center_i[i]});
        dd_q[i] <= dd_d[i];
        dq_q[i] <= dq_d[i];
        qq_q[i] <= qq_d[i];
      end
      r_q     <= radius_i;
      rr_q    <= rsi_pkg::RR_W'(r_q) * rsi_pkg::RR_W'(r_q);
      a_q     <= a_d;
      b_q     <= b_d;
      c_q     <= c_d;
      a2_q    <= a_q;
      bmag_q  <= babs[rsi_pkg::BMAG_W-1:0];
      cmag_q  <= cabs[rsi_pkg::CMAG_W-1:0];
      flags_q <= flags_d;
    end
  end

  assign valid_o = vld_q[3];
  assign a_o     = a2_q;
  assign bmag_o  = bmag_q;
  assign cmag_o  = cmag_q;
  assign flags_o = flags_q;

endmodule

>>> rtl/rsi_mul.sv
// Wide unsigned multiplier built from four 33x33 partial products over three stages.
module rsi_mul (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [rsi_pkg::MUL_W-1:0]   a_i,
  input  logic [rsi_pkg::MUL_W-1:0]   b_i,
  output logic [rsi_pkg::PROD_W-1:0]  p_o
);

  localparam int unsigned LW = rsi_pkg::MUL_W / 2;

  logic [2*LW-1:0]             p00_q, p01_q, p10_q, p11_q;
  logic [2*LW:0]               mid_q;
  logic [rsi_pkg::PROD_W-1:0]  cat_q, p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p00_q <= (2*LW)'(a_i[LW-1:0])  * (2*LW)'(b_i[LW-1:0]);
      p01_q <= (2*LW)'(a_i[LW-1:0])  * (2*LW)'(b_i[2*LW-1:LW]);
      p10_q <= (2*LW)'(a_i[2*LW-1:LW]) * (2*LW)'(b_i[LW-1:0]);
      p11_q <= (2*LW)'(a_i[2*LW-1:LW]) * (2*LW)'(b_i[2*LW-1:LW]);
      mid_q <= (2*LW+1)'(p01_q) + (2*LW+1)'(p10_q);
      cat_q <= {p11_q, p00_q};
      p_q   <= cat_q + (rsi_pkg::PROD_W'(mid_q) << LW);
    end
  end

  assign p_o = p_q;

endmodule

>>> rtl/rsi_sqrt.sv
// Pipelined integer square root of disc * 4^FRAC_BITS, one root bit per stage.
module rsi_sqrt #(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned SIDE_W    = 8,
  localparam int unsigned RB       = (rsi_pkg::DISC_W + 2 * FRAC_BITS) / 2
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  logic [rsi_pkg::DISC_W-1:0]   rad_i,
  input  logic [SIDE_W-1:0]            side_i,
  output logic                         valid_o,
  output logic [RB-1:0]                root_o,
  output logic                         exact_o,
  output logic [SIDE_W-1:0]            side_o
);

  localparam int unsigned RADW = 2 * RB;
  localparam int unsigned RW   = RB + 4;

  logic [RADW-1:0]   rad_q  [RB];
  logic [RW-1:0]     rem_q  [RB];
  logic [RB-1:0]     root_q [RB];
  logic [SIDE_W-1:0] side_q [RB];
  logic [RB-1:0]     vld_q;

  for (genvar k = 0; k < RB; k++) begin : g_stage
    logic [RADW-1:0]   rad_p;
    logic [RW-1:0]     rem_p, rem_t, trial;
    logic [RB-1:0]     root_p;
    logic [SIDE_W-1:0] side_p;
    logic              vld_p, ge;

    if (k == 0) begin : g_first
      assign rad_p  = {rad_i, {(2 * FRAC_BITS){1'b0}}};
      assign rem_p  = '0;
      assign root_p = '0;
      assign side_p = side_i;
      assign vld_p  = valid_i;
    end else begin : g_next
      assign rad_p  = rad_q[k-1];
      assign rem_p  = rem_q[k-1];
      assign root_p = root_q[k-1];
      assign side_p = side_q[k-1];
      assign vld_p  = vld_q[k-1];
    end

    assign rem_t = {rem_p[RW-3:0], rad_p[RADW-1 -: 2]};
    assign trial = RW'({root_p, 2'b01});
    assign ge    = (rem_t >= trial);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[k]  <= rad_p << 2;
        rem_q[k]  <= ge ? rem_t - trial : rem_t;
        root_q[k] <= {root_p[RB-2:0], ge};
        side_q[k] <= side_p;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_p;
      end
    end
  end

  assign valid_o = vld_q[RB-1];
  assign root_o  = root_q[RB-1];
  assign exact_o = (rem_q[RB-1] == '0);
  assign side_o  = side_q[RB-1];

endmodule

>>> rtl/rsi_div.sv
// Pipelined restoring divider: floor(n / a) with saturation, one quotient bit per stage.
module rsi_div #(
  parameter int unsigned NW = 83
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [NW-1:0]             n_i,
  input  logic [rsi_pkg::A_W-1:0]   a_i,
  input  logic                      hit_i,
  output logic                      valid_o,
  output logic [rsi_pkg::T_W-1:0]   t_o,
  output logic                      hit_o
);

  localparam int unsigned TW  = rsi_pkg::T_W;
  localparam int unsigned AW  = rsi_pkg::A_W;
  localparam int unsigned LIM = AW + TW;
  localparam int unsigned NXW = (NW > LIM) ? NW : LIM;

  logic [NXW-1:0] nx;
  logic           sat_d;

  logic [AW-1:0] rem_q  [TW+1];
  logic [TW-1:0] low_q  [TW+1];
  logic [TW-1:0] quo_q  [TW+1];
  logic [AW-1:0] a_q    [TW+1];
  logic          sat_q  [TW+1];
  logic          hit_q  [TW+1];
  logic [TW:0]   vld_q;

  assign nx    = NXW'(n_i);
  assign sat_d = (nx >= NXW'({a_i, {TW{1'b0}}}));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= sat_d ? '0 : nx[LIM-1:TW];
      low_q[0] <= nx[TW-1:0];
      quo_q[0] <= '0;
      a_q[0]   <= a_i;
      sat_q[0] <= sat_d;
      hit_q[0] <= hit_i;
    end
  end

  for (genvar k = 0; k < TW; k++) begin : g_step
    logic [AW:0] rem_t, diff;
    logic        ge;

    assign rem_t = {rem_q[k], low_q[k][TW-1]};
    assign diff  = rem_t - {1'b0, a_q[k]};
    assign ge    = (rem_t >= {1'b0, a_q[k]});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1] <= ge ? diff[AW-1:0] : rem_t[AW-1:0];
        low_q[k+1] <= low_q[k] << 1;
        quo_q[k+1] <= {quo_q[k][TW-2:0], ge};
        a_q[k+1]   <= a_q[k];
        sat_q[k+1] <= sat_q[k];
        hit_q[k+1] <= hit_q[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[TW-1:0], valid_i};
    end
  end

  assign valid_o = vld_q[TW];
  assign t_o     = sat_q[TW] ? '1 : quo_q[TW];
  assign hit_o   = hit_q[TW];

endmodule

>>> rtl/ray_sphere_intersection_unit.sv
// Ray-sphere intersection unit: top level pipeline.
// Takes one ray/sphere test per cycle while the output is not stalled and returns
// one result per test, in order. It has 4 front-end stages, 3 for the wide
// products, 1 for the discriminant, 66 + FRAC_BITS square-root stages (one root
// bit each), 1 to form the numerator, 33 divider stages (one quotient bit each)
// and the output register. The whole pipeline advances together and holds while
// a result waits at the output.
module ray_sphere_intersection_unit #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, center_x, center_y,
  // center_z (32 each), radius (31), one zero pad bit
  input  logic [rsi_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // t_hit (32)
  output logic [rsi_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // hit (1)
  output logic                               m_axis_tuser
);

  localparam int unsigned CW = rsi_pkg::COORD_W;
  localparam int unsigned RB = (rsi_pkg::DISC_W + 2 * FRAC_BITS) / 2;
  localparam int unsigned NW = rsi_pkg::BMAG_W + FRAC_BITS + 2;
  localparam int unsigned SW = $bits(rsi_pkg::root_side_t);

  logic en;
  logic out_vld_q, out_hit_q;
  logic [rsi_pkg::T_W-1:0] out_t_q;

  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  // unpack input fields
  logic [CW-1:0] origin [3], dir [3], center [3];
  for (genvar i = 0; i < 3; i++) begin : g_fields
    assign origin[i] = s_axis_tdata[i*CW +: CW];
    assign dir[i]    = s_axis_tdata[(i+3)*CW +: CW];
    assign center[i] = s_axis_tdata[(i+6)*CW +: CW];
  end

  logic                           fr_vld;
  logic [rsi_pkg::A_W-1:0]        fr_a;
  logic [rsi_pkg::BMAG_W-1:0]     fr_bmag;
  logic [rsi_pkg::CMAG_W-1:0]     fr_cmag;
  rsi_pkg::sign_flags_t           fr_flags;

  rsi_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (s_axis_tvalid),
    .origin_i (origin),
    .dir_i    (dir),
    .center_i (center),
    .radius_i (s_axis_tdata[9*CW +: rsi_pkg::RAD_W]),
    .valid_o  (fr_vld),
    .a_o      (fr_a),
    .bmag_o   (fr_bmag),
    .cmag_o   (fr_cmag),
    .flags_o  (fr_flags)
  );

  logic [rsi_pkg::PROD_W-1:0] b2, ac;

  rsi_mul u_mul_bb (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   (rsi_pkg::MUL_W'(fr_bmag)),
    .b_i   (rsi_pkg::MUL_W'(fr_bmag)),
    .p_o   (b2)
  );

  rsi_mul u_mul_ac (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   (rsi_pkg::MUL_W'(fr_a)),
    .b_i   (rsi_pkg::MUL_W'(fr_cmag)),
    .p_o   (ac)
  );

  // side data travels alongside the multipliers
  rsi_pkg::mul_side_t         ms_q  [rsi_pkg::MUL_LAT];
  logic [rsi_pkg::MUL_LAT-1:0] ms_vld_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ms_q[0] <= '{a: fr_a, bmag: fr_bmag, flags: fr_flags};
      for (int i = 1; i < rsi_pkg::MUL_LAT; i++) ms_q[i] <= ms_q[i-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ms_vld_q <= '0;
    end else if (en) begin
      ms_vld_q <= {ms_vld_q[rsi_pkg::MUL_LAT-2:0], fr_vld};
    end
  end

  // discriminant B^2 - A*C
  logic [rsi_pkg::DISC_W-1:0] disc_d, disc_q;
  logic                       disc_neg_q, disc_vld_q;
  rsi_pkg::mul_side_t         dside_q;

  always_comb begin
    if (ms_q[rsi_pkg::MUL_LAT-1].flags.c_neg) begin
      disc_d = b2 + ac;
    end else begin
      disc_d = b2 - ac;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      disc_q     <= disc_d;
      disc_neg_q <= !ms_q[rsi_pkg::MUL_LAT-1].flags.c_neg && disc_d[rsi_pkg::DISC_W-1];
      dside_q    <= ms_q[rsi_pkg::MUL_LAT-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      disc_vld_q <= 1'b0;
    end else if (en) begin
      disc_vld_q <= ms_vld_q[rsi_pkg::MUL_LAT-1];
    end
  end

  // root selection and hit decision
  rsi_pkg::root_side_t rs_in, rs_out;
  logic b_nonpos, disc_zero;

  always_comb begin
    b_nonpos  = dside_q.flags.b_neg || dside_q.flags.b_zero;
    disc_zero = (disc_q == '0);
    rs_in.a    = dside_q.a;
    rs_in.bmag = dside_q.bmag;
    // a tangent ray through the origin point (B == 0) does not count
    rs_in.hit  = dside_q.flags.a_nz && !disc_neg_q && !(disc_zero && dside_q.flags.b_zero)
                 && (b_nonpos || dside_q.flags.c_neg || dside_q.flags.c_zero);
    if (b_nonpos && !dside_q.flags.c_neg) begin
      rs_in.nsel = rsi_pkg::NSEL_SUB_CEIL;
    end else if (b_nonpos) begin
      rs_in.nsel = rsi_pkg::NSEL_ADD;
    end else begin
      rs_in.nsel = rsi_pkg::NSEL_REV;
    end
  end

  logic            sq_vld, sq_exact;
  logic [RB-1:0]   sq_root;
  logic [SW-1:0]   sq_side;

  rsi_sqrt #(
    .FRAC_BITS (FRAC_BITS),
    .SIDE_W    (SW)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (disc_vld_q),
    .rad_i   (disc_neg_q ? '0 : disc_q),
    .side_i  (SW'(rs_in)),
    .valid_o (sq_vld),
    .root_o  (sq_root),
    .exact_o (sq_exact),
    .side_o  (sq_side)
  );

  assign rs_out = rsi_pkg::root_side_t'(sq_side);

  // numerator of the chosen root
  logic [NW-1:0]           bsh, n_d, n_q;
  logic [rsi_pkg::A_W-1:0] na_q;
  logic                    nhit_q, nvld_q;

  always_comb begin
    bsh = NW'({rs_out.bmag, {FRAC_BITS{1'b0}}});
    unique case (rs_out.nsel)
      rsi_pkg::NSEL_SUB_CEIL: n_d = bsh - NW'(sq_root) - NW'(!sq_exact);
      rsi_pkg::NSEL_ADD:      n_d = bsh + NW'(sq_root);
      rsi_pkg::NSEL_REV:      n_d = NW'(sq_root) - bsh;
      default:                n_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      n_q    <= n_d;
      na_q   <= rs_out.a;
      nhit_q <= rs_out.hit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nvld_q <= 1'b0;
    end else if (en) begin
      nvld_q <= sq_vld;
    end
  end

  logic                    dv_vld, dv_hit;
  logic [rsi_pkg::T_W-1:0] dv_t;

  rsi_div #(
    .NW (NW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (nvld_q),
    .n_i     (n_q),
    .a_i     (na_q),
    .hit_i   (nhit_q),
    .valid_o (dv_vld),
    .t_o     (dv_t),
    .hit_o   (dv_hit)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_hit_q <= dv_hit;
      out_t_q   <= dv_hit ? dv_t : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= dv_vld;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_t_q;
  assign m_axis_tuser  = out_hit_q;

endmodule

>>> rtl/rsi_sva.sv
// Port-level checks for the ray-sphere intersection unit, bound to the top level.
module rsi_sva (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [rsi_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  input logic                             m_axis_tuser
);

  // a held result keeps its value until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                        && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // a miss carries t_hit of zero
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("miss with nonzero t_hit");

  // empty output stage never blocks the input
  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  // a taken result frees the pipeline in the same cycle
  a_ready_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready |-> s_axis_tready)
    else $error("input stalled while result transfers");

endmodule

bind ray_sphere_intersection_unit rsi_sva u_rsi_sva (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
